// File: src/lobm_pkg.sv
// Shared types and codes of the limit order book matcher.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lobm_pkg;

  localparam int LOBM_MAX_USERS  = 256;
  localparam int LOBM_BOOK_DEPTH = 64;
  localparam int BAL_W           = 48;

  // Action codes; codes four to seven behave as a balance read.
  localparam logic [2:0] ACT_REGISTER = 3'd0;
  localparam logic [2:0] ACT_DEPOSIT  = 3'd1;
  localparam logic [2:0] ACT_SELL     = 3'd2;
  localparam logic [2:0] ACT_BUY      = 3'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_REJECT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // One resting offer.
  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] usd;
    logic [15:0] price;
  } book_entry_t;

endpackage

// File: src/lobm_book_ram.sv
// Offer storage for one side of the book: one write and one registered read port.
// Depends on lobm_pkg for the entry type.
`timescale 1ns / 1ps

module lobm_book_ram
  import lobm_pkg::*;
#(
  parameter int DEPTH = LOBM_BOOK_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  book_entry_t   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output book_entry_t   rdata_o
);

  book_entry_t mem_q [DEPTH];
  book_entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/lobm_addsub.sv
// Shared balance adder and subtractor used for every deposit and trade balance update.
// Depends on lobm_pkg for the balance width.
`timescale 1ns / 1ps

module lobm_addsub
  import lobm_pkg::*;
(
  input  logic [BAL_W-1:0] a_i,
  input  logic [BAL_W-1:0] b_i,
  input  logic             sub_i,
  output logic [BAL_W-1:0] y_o
);

  // Balances wrap modulo two to the balance width.
  assign y_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule

// File: src/limit_order_book_matcher_top.sv
// One item at a time: the input stalls while an item is in work. An accepted offer
// first moves past resting offers during sorted insertion, a read and a write per
// entry moved, then in matching inspects the fronts, makes the four balance updates
// of each trade through the single shared adder, updates the front entries, and
// shifts the entries behind a filled offer forward, a read and a write per entry
// shifted; these steps are set by the one read port of each book memory and of the
// balance memories. No clearing pass: a user's balances are zeroed when the user
// registers, and entries past the fill are never read.
// Depends on lobm_pkg, lobm_book_ram and lobm_addsub.
`timescale 1ns / 1ps

module limit_order_book_matcher_top
  import lobm_pkg::*;
#(
  parameter int MAX_USERS  = LOBM_MAX_USERS,
  parameter int BOOK_DEPTH = LOBM_BOOK_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        action_i,
  input  logic [7:0]        user_id_i,
  input  logic [15:0]       amount_usd_i,
  input  logic [15:0]       price_rub_i,
  input  logic signed [31:0] deposit_rub_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [7:0]        result_user_o,
  output logic signed [47:0] usd_balance_o,
  output logic signed [47:0] rub_balance_o,
  output logic [7:0]        trades_done_o
);

  localparam int CW = $clog2(MAX_USERS + 1);
  localparam int IW = $clog2(MAX_USERS);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam int FW = $clog2(BOOK_DEPTH + 1);
  localparam int BW = $clog2(BOOK_DEPTH);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_REG     = 5'd1;
  localparam logic [4:0] S_DEP_RD  = 5'd2;
  localparam logic [4:0] S_DEP_WR  = 5'd3;
  localparam logic [4:0] S_INS_RD  = 5'd4;
  localparam logic [4:0] S_INS_CMP = 5'd5;
  localparam logic [4:0] S_M_RD    = 5'd6;
  localparam logic [4:0] S_M_CMP   = 5'd7;
  localparam logic [4:0] S_SEL_RD  = 5'd8;
  localparam logic [4:0] S_SEL_USD = 5'd9;
  localparam logic [4:0] S_SEL_RUB = 5'd10;
  localparam logic [4:0] S_BUY_RD  = 5'd11;
  localparam logic [4:0] S_BUY_USD = 5'd12;
  localparam logic [4:0] S_BUY_RUB = 5'd13;
  localparam logic [4:0] S_UPD     = 5'd14;
  localparam logic [4:0] S_RM_RD   = 5'd15;
  localparam logic [4:0] S_RM_WR   = 5'd16;
  localparam logic [4:0] S_FIN_RD  = 5'd17;
  localparam logic [4:0] S_FIN     = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0] state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [FW-1:0] sfill_q, sfill_d, bfill_q, bfill_d;
  logic [FW-1:0] idx_q, idx_d, b_q, b_d;
  logic rm_sell_q, rm_sell_d, pend_q, pend_d;
  logic sell_q, sell_d;
  logic [7:0] uid_q, uid_d;
  logic [15:0] amt_q, amt_d, price_q, price_d;
  logic [31:0] dep_q, dep_d;
  logic [1:0] status_q, status_d;
  logic [7:0] ruser_q, ruser_d, trades_q, trades_d;
  logic [BAL_W-1:0] res_usd_q, res_usd_d, res_rub_q, res_rub_d;
  book_entry_t se_q, se_d, be_q, be_d;
  logic [15:0] qty_q, qty_d;
  logic [31:0] rub_amt_q, rub_amt_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] o_status_q, o_status_d;
  logic [7:0] o_user_q, o_user_d, o_trades_q, o_trades_d;
  logic [BAL_W-1:0] o_usd_q, o_usd_d, o_rub_q, o_rub_d;

  // Balance memories.
  logic [BAL_W-1:0] usd_mem_q [MAX_USERS];
  logic [BAL_W-1:0] rub_mem_q [MAX_USERS];
  logic [BAL_W-1:0] usd_rd_q, rub_rd_q;
  logic [IW-1:0] bal_raddr, bal_waddr;
  logic usd_we, rub_we, bal_zero;

  // Book ports.
  logic sell_we, buy_we;
  logic [BW-1:0] sell_waddr, buy_waddr, sell_raddr, buy_raddr;
  book_entry_t sell_wdata, buy_wdata, sell_rdata, buy_rdata;

  // Shared adder.
  logic [BAL_W-1:0] alu_a, alu_b, alu_y;
  logic alu_sub;

  logic [XW-1:0] uid_in_x, uid_x, cnt_x, sel_x, buy_x;
  logic [IW-1:0] uid_idx, seller_idx, buyer_idx;
  book_entry_t new_e, rm_rd;
  logic [FW-1:0] fill_cur, idx_m1, idx_p1;
  logic ins_stop;
  logic [15:0] qty_min;

  assign uid_in_x   = XW'(user_id_i);
  assign uid_x      = XW'(uid_q);
  assign cnt_x      = XW'(count_q);
  assign sel_x      = XW'(se_q.owner);
  assign buy_x      = XW'(be_q.owner);
  assign uid_idx    = uid_x[IW-1:0];
  assign seller_idx = sel_x[IW-1:0];
  assign buyer_idx  = buy_x[IW-1:0];
  assign new_e      = '{owner: uid_q, usd: amt_q, price: price_q};
  assign idx_m1     = idx_q - FW'(1);
  assign idx_p1     = idx_q + FW'(1);
  assign fill_cur   = rm_sell_q ? sfill_q : bfill_q;
  assign rm_rd      = rm_sell_q ? sell_rdata : buy_rdata;
  assign qty_min    = (sell_rdata.usd < buy_rdata.usd) ? sell_rdata.usd : buy_rdata.usd;

  // Insertion stops at the first entry from the back that stays in front.
  always_comb begin
    book_entry_t d;
    d = sell_q ? sell_rdata : buy_rdata;
    ins_stop = sell_q ? (d.price < price_q) : (d.price > price_q);
  end

  lobm_book_ram #(.DEPTH(BOOK_DEPTH)) u_sell (
    .clk_i, .we_i(sell_we), .waddr_i(sell_waddr), .wdata_i(sell_wdata),
    .raddr_i(sell_raddr), .rdata_o(sell_rdata)
  );

  lobm_book_ram #(.DEPTH(BOOK_DEPTH)) u_buy (
    .clk_i, .we_i(buy_we), .waddr_i(buy_waddr), .wdata_i(buy_wdata),
    .raddr_i(buy_raddr), .rdata_o(buy_rdata)
  );

  lobm_addsub u_alu (.a_i(alu_a), .b_i(alu_b), .sub_i(alu_sub), .y_o(alu_y));

  // Adder operand selection by sequencer step.
  always_comb begin
    alu_a   = ((state_q == S_SEL_USD) || (state_q == S_BUY_USD)) ? usd_rd_q : rub_rd_q;
    alu_sub = (state_q == S_SEL_USD) || (state_q == S_BUY_RUB);
    unique case (state_q)
      S_SEL_USD, S_BUY_USD: alu_b = BAL_W'(qty_q);
      S_DEP_WR:             alu_b = {{(BAL_W - 32){dep_q[31]}}, dep_q};
      default:              alu_b = BAL_W'(rub_amt_q);
    endcase
  end

  // Balance memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (usd_we) begin
      usd_mem_q[bal_waddr] <= bal_zero ? '0 : alu_y;
    end
    if (rub_we) begin
      rub_mem_q[bal_waddr] <= bal_zero ? '0 : alu_y;
    end
    usd_rd_q <= usd_mem_q[bal_raddr];
    rub_rd_q <= rub_mem_q[bal_raddr];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sfill_d     = sfill_q;
    bfill_d     = bfill_q;
    idx_d       = idx_q;
    b_d         = b_q;
    rm_sell_d   = rm_sell_q;
    pend_d      = pend_q;
    sell_d      = sell_q;
    uid_d       = uid_q;
    amt_d       = amt_q;
    price_d     = price_q;
    dep_d       = dep_q;
    status_d    = status_q;
    ruser_d     = ruser_q;
    trades_d    = trades_q;
    res_usd_d   = res_usd_q;
    res_rub_d   = res_rub_q;
    se_d        = se_q;
    be_d        = be_q;
    qty_d       = qty_q;
    rub_amt_d   = rub_amt_q;
    out_valid_d = out_valid_q & out_stall_i;
    o_status_d  = o_status_q;
    o_user_d    = o_user_q;
    o_trades_d  = o_trades_q;
    o_usd_d     = o_usd_q;
    o_rub_d     = o_rub_q;
    bal_raddr   = uid_idx;
    bal_waddr   = uid_idx;
    usd_we      = 1'b0;
    rub_we      = 1'b0;
    bal_zero    = 1'b0;
    sell_we     = 1'b0;
    buy_we      = 1'b0;
    sell_waddr  = idx_q[BW-1:0];
    buy_waddr   = idx_q[BW-1:0];
    sell_wdata  = new_e;
    buy_wdata   = new_e;
    sell_raddr  = idx_m1[BW-1:0];
    buy_raddr   = idx_m1[BW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          uid_d     = user_id_i;
          amt_d     = amount_usd_i;
          price_d   = price_rub_i;
          dep_d     = deposit_rub_i;
          sell_d    = (action_i == ACT_SELL);
          status_d  = ST_OK;
          ruser_d   = user_id_i;
          trades_d  = '0;
          res_usd_d = '0;
          res_rub_d = '0;
          if (action_i == ACT_REGISTER) begin
            if (count_q == CW'(MAX_USERS)) begin
              status_d = ST_FULL;
              ruser_d  = '0;
              state_d  = S_DONE;
            end else begin
              state_d = S_REG;
            end
          end else if (uid_in_x >= cnt_x) begin
            status_d = ST_UNKNOWN;
            state_d  = S_DONE;
          end else if (action_i == ACT_DEPOSIT) begin
            state_d = S_DEP_RD;
          end else if ((action_i == ACT_SELL) || (action_i == ACT_BUY)) begin
            if ((amount_usd_i == '0) || (price_rub_i == '0)) begin
              status_d = ST_REJECT;
              state_d  = S_FIN_RD;
            end else if (((action_i == ACT_SELL) ? sfill_q : bfill_q)
                         == FW'(BOOK_DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_FIN_RD;
            end else begin
              idx_d   = (action_i == ACT_SELL) ? sfill_q : bfill_q;
              state_d = S_INS_RD;
            end
          end else begin
            state_d = S_FIN_RD;
          end
        end
      end
      S_REG: begin
        bal_waddr = cnt_x[IW-1:0];
        usd_we    = 1'b1;
        rub_we    = 1'b1;
        bal_zero  = 1'b1;
        ruser_d   = 8'(count_q);
        count_d   = count_q + CW'(1);
        state_d   = S_DONE;
      end
      S_DEP_RD: begin
        state_d = S_DEP_WR;
      end
      S_DEP_WR: begin
        rub_we  = 1'b1;
        state_d = S_FIN_RD;
      end
      // Sorted insertion from the back: each entry moved is read, then written one place back.
      S_INS_RD: begin
        if (idx_q == '0) begin
          sell_we = sell_q;
          buy_we  = !sell_q;
          if (sell_q) sfill_d = sfill_q + FW'(1);
          else        bfill_d = bfill_q + FW'(1);
          b_d     = '0;
          state_d = S_M_RD;
        end else begin
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        sell_we = sell_q;
        buy_we  = !sell_q;
        if (ins_stop) begin
          if (sell_q) sfill_d = sfill_q + FW'(1);
          else        bfill_d = bfill_q + FW'(1);
          b_d     = '0;
          state_d = S_M_RD;
        end else begin
          sell_wdata = sell_rdata;
          buy_wdata  = buy_rdata;
          idx_d      = idx_m1;
          state_d    = S_INS_RD;
        end
      end
      // Matching of the book fronts.
      S_M_RD: begin
        sell_raddr = '0;
        buy_raddr  = b_q[BW-1:0];
        if ((sfill_q == '0) || (b_q >= bfill_q)) begin
          state_d = S_FIN_RD;
        end else begin
          state_d = S_M_CMP;
        end
      end
      S_M_CMP: begin
        se_d      = sell_rdata;
        be_d      = buy_rdata;
        qty_d     = qty_min;
        rub_amt_d = qty_min * buy_rdata.price;
        if (sell_rdata.price > buy_rdata.price) begin
          state_d = S_FIN_RD;
        end else if (sell_rdata.owner == buy_rdata.owner) begin
          b_d     = b_q + FW'(1);
          state_d = S_M_RD;
        end else begin
          trades_d = trades_q + 8'd1;
          state_d  = S_SEL_RD;
        end
      end
      S_SEL_RD: begin
        bal_raddr = seller_idx;
        state_d   = S_SEL_USD;
      end
      S_SEL_USD: begin
        bal_raddr = seller_idx;
        bal_waddr = seller_idx;
        usd_we    = 1'b1;
        state_d   = S_SEL_RUB;
      end
      S_SEL_RUB: begin
        bal_raddr = buyer_idx;
        bal_waddr = seller_idx;
        rub_we    = 1'b1;
        state_d   = S_BUY_RD;
      end
      S_BUY_RD: begin
        bal_raddr = buyer_idx;
        state_d   = S_BUY_USD;
      end
      S_BUY_USD: begin
        bal_raddr = buyer_idx;
        bal_waddr = buyer_idx;
        usd_we    = 1'b1;
        state_d   = S_BUY_RUB;
      end
      S_BUY_RUB: begin
        bal_waddr = buyer_idx;
        rub_we    = 1'b1;
        state_d   = S_UPD;
      end
      // The larger entry keeps the remainder; emptied entries are removed.
      S_UPD: begin
        state_d = S_RM_RD;
        pend_d  = 1'b0;
        if (se_q.usd > be_q.usd) begin
          sell_we    = 1'b1;
          sell_waddr = '0;
          sell_wdata = '{owner: se_q.owner, usd: se_q.usd - be_q.usd, price: se_q.price};
          rm_sell_d  = 1'b0;
          idx_d      = b_q;
        end else if (se_q.usd < be_q.usd) begin
          buy_we     = 1'b1;
          buy_waddr  = b_q[BW-1:0];
          buy_wdata  = '{owner: be_q.owner, usd: be_q.usd - se_q.usd, price: be_q.price};
          rm_sell_d  = 1'b1;
          idx_d      = '0;
        end else begin
          rm_sell_d = 1'b1;
          idx_d     = '0;
          pend_d    = 1'b1;
        end
      end
      S_RM_RD: begin
        sell_raddr = idx_p1[BW-1:0];
        buy_raddr  = idx_p1[BW-1:0];
        if (idx_p1 >= fill_cur) begin
          if (rm_sell_q) sfill_d = sfill_q - FW'(1);
          else           bfill_d = bfill_q - FW'(1);
          if (pend_q) begin
            pend_d    = 1'b0;
            rm_sell_d = 1'b0;
            idx_d     = b_q;
          end else begin
            state_d = S_M_RD;
          end
        end else begin
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        sell_we    = rm_sell_q;
        buy_we     = !rm_sell_q;
        sell_wdata = rm_rd;
        buy_wdata  = rm_rd;
        idx_d      = idx_p1;
        state_d    = S_RM_RD;
      end
      S_FIN_RD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        res_usd_d = usd_rd_q;
        res_rub_d = rub_rd_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          o_status_d  = status_q;
          o_user_d    = ruser_q;
          o_trades_d  = trades_q;
          o_usd_d     = res_usd_q;
          o_rub_d     = res_rub_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sfill_q     <= '0;
      bfill_q     <= '0;
      idx_q       <= '0;
      b_q         <= '0;
      rm_sell_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sfill_q     <= sfill_d;
      bfill_q     <= bfill_d;
      idx_q       <= idx_d;
      b_q         <= b_d;
      rm_sell_q   <= rm_sell_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sell_q     <= sell_d;
    uid_q      <= uid_d;
    amt_q      <= amt_d;
    price_q    <= price_d;
    dep_q      <= dep_d;
    status_q   <= status_d;
    ruser_q    <= ruser_d;
    trades_q   <= trades_d;
    res_usd_q  <= res_usd_d;
    res_rub_q  <= res_rub_d;
    se_q       <= se_d;
    be_q       <= be_d;
    qty_q      <= qty_d;
    rub_amt_q  <= rub_amt_d;
    o_status_q <= o_status_d;
    o_user_q   <= o_user_d;
    o_trades_q <= o_trades_d;
    o_usd_q    <= o_usd_d;
    o_rub_q    <= o_rub_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign result_user_o = o_user_q;
  assign usd_balance_o = o_usd_q;
  assign rub_balance_o = o_rub_q;
  assign trades_done_o = o_trades_q;

  // Fill levels never pass their limits.
  a_book_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sfill_q <= FW'(BOOK_DEPTH)) && (bfill_q <= FW'(BOOK_DEPTH)))
    else $error("book fill beyond depth");

  a_user_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_USERS))
    else $error("user count beyond table size");

  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted item left idle");

  // A settled trade never pairs an owner with itself.
  a_no_self_trade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEL_RD) |-> (se_q.owner != be_q.owner))
    else $error("self trade settled");

endmodule
